@@ hdl/indexed_list_buffer_defines.svh @@
// Assertion macros used by the checker of the indexed list buffer.
// Needs nothing else; included by the checker file.
`ifndef INDEXED_LIST_BUFFER_DEFINES_SVH
`define INDEXED_LIST_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ILB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ILB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ilb_pkg.sv @@
// Package of the indexed list buffer: field widths, request kinds, status codes,
// transfer payload types and the memory control group. Depends on nothing.
`default_nettype none

package ilb_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ       = 3'd0,
      KIND_INSERT     = 3'd1,
      KIND_PUSH_BACK  = 3'd2,
      KIND_PUSH_FRONT = 3'd3,
      KIND_POP_BACK   = 3'd4,
      KIND_POP_FRONT  = 3'd5,
      KIND_CLEAR      = 3'd6
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

@@ hdl/ilb_store.sv @@
// Entry memory of the indexed list buffer: one write port and one registered read port.
// Depends on ilb_pkg for the memory control group.
`default_nettype none

module ilb_store #(
   parameter int CAPACITY   = ilb_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = ilb_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  ilb_pkg::mem_ctl_type        mem_ctl,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]       wr_data,
   output logic [DATA_WIDTH-1:0]       rd_data
);
   import ilb_pkg::*;

   logic [DATA_WIDTH-1:0] mem_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/ilb_seq.sv @@
// Sequencer of the indexed list buffer: decodes a request, keeps the entry count and
// moves entries one at a time through the shared index adder. Depends on ilb_pkg.
`default_nettype none

module ilb_seq #(
   parameter int CAPACITY   = ilb_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = ilb_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ilb_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ilb_pkg::rsp_type            rsp_payload,
   output ilb_pkg::mem_ctl_type        mem_ctl,
   output logic [$clog2(CAPACITY)-1:0] rd_addr,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output logic [DATA_WIDTH-1:0]       wr_data,
   input  logic [DATA_WIDTH-1:0]       rd_data
);
   import ilb_pkg::*;

   localparam int AW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CW > POS_W) ? CW : POS_W;
   localparam int IO_W   = (VALUE_W > DATA_W) ? VALUE_W : DATA_W;
   localparam int WIDE_W = (DATA_WIDTH > IO_W) ? DATA_WIDTH : IO_W;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_RD_WAIT = 8'b0000_0010,
      ST_UP_RD   = 8'b0000_0100,
      ST_UP_WR   = 8'b0000_1000,
      ST_INS_WR  = 8'b0001_0000,
      ST_DN_RD   = 8'b0010_0000,
      ST_DN_WR   = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         target_ff, target_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_W-1:0]     data_ff, data_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  at_ext;
   logic [CW-1:0]     cnt_dec;
   logic [WIDE_W-1:0] value_wide;
   logic [WIDE_W-1:0] rd_wide;
   logic              adj_up;
   logic [CW-1:0]     idx_adj;
   logic [CW-1:0]     cmp_a;
   logic              cmp_hit;

   // The one index adder and comparator that every move step shares.
   always_comb begin
      adj_up  = (state_ff == ST_DN_RD) || (state_ff == ST_DN_WR);
      idx_adj = adj_up ? idx_ff + 1'b1 : idx_ff - 1'b1;
      cmp_a   = (state_ff == ST_RD_WAIT) ? idx_ff : idx_adj;
      cmp_hit = (cmp_a == target_ff);
   end

   always_comb begin
      pos_ext    = CMP_W'(req_payload.position);
      cnt_ext    = CMP_W'(cnt_ff);
      cnt_dec    = cnt_ff - 1'b1;
      value_wide = WIDE_W'(req_payload.value);
      rd_wide    = WIDE_W'(rd_data);
      unique case (req_payload.kind)
         KIND_INSERT:     at_ext = pos_ext;
         KIND_PUSH_BACK:  at_ext = cnt_ext;
         default:         at_ext = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      target_in    = target_ff;
      word_in      = word_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_ctl      = '0;
      rd_addr      = idx_adj[AW-1:0];
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data;
      req_ready    = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               data_in   = '0;
               status_in = STATUS_OK;
               word_in   = value_wide[DATA_WIDTH-1:0];
               idx_in    = '0;
               target_in = '0;
               state_in  = ST_DONE;
               unique case (req_payload.kind)
                  KIND_READ: begin
                     if (pos_ext < cnt_ext) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = pos_ext[AW-1:0];
                        state_in      = ST_RD_WAIT;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  KIND_INSERT, KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                     if (at_ext > cnt_ext) begin
                        status_in = STATUS_RANGE;
                     end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        idx_in    = cnt_ff;
                        target_in = at_ext[CW-1:0];
                        state_in  = (at_ext == cnt_ext) ? ST_INS_WR : ST_UP_RD;
                     end
                  end
                  KIND_POP_BACK: begin
                     if (cnt_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        cnt_in        = cnt_dec;
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = cnt_dec[AW-1:0];
                        state_in      = ST_RD_WAIT;
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (cnt_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        cnt_in        = cnt_dec;
                        target_in     = cnt_dec;
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        state_in      = ST_RD_WAIT;
                     end
                  end
                  KIND_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            data_in  = rd_wide[DATA_W-1:0];
            state_in = cmp_hit ? ST_DONE : ST_DN_RD;
         end
         ST_UP_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = ST_UP_WR;
         end
         ST_UP_WR: begin
            mem_ctl.wr_en = 1'b1;
            idx_in        = idx_adj;
            state_in      = cmp_hit ? ST_INS_WR : ST_UP_RD;
         end
         ST_INS_WR: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = target_ff[AW-1:0];
            wr_data       = word_ff;
            cnt_in        = cnt_ff + 1'b1;
            state_in      = ST_DONE;
         end
         ST_DN_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = ST_DN_WR;
         end
         ST_DN_WR: begin
            mem_ctl.wr_en = 1'b1;
            idx_in        = idx_adj;
            state_in      = cmp_hit ? ST_DONE : ST_DN_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.data        = data_ff;
               rsp_in.status      = status_ff;
               rsp_in.entry_count = cnt_ext[COUNT_W-1:0];
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      target_ff <= target_in;
      word_ff   <= word_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/indexed_list_buffer.sv @@
// Top level of the indexed list buffer: the sequencer and the entry memory.
// Depends on ilb_pkg, ilb_seq and ilb_store.
//
// The block holds an ordered list of up to CAPACITY words and serves one request
// at a time; req_ready is high only while no request is in progress. A clear, an
// unused kind or any request that fails goes from idle straight to the done state,
// which loads its result into the output register once that register is free; a
// read or a pop back first passes a state that waits for the registered read. An
// insert or push moves each entry from its index upward up by one place, last entry
// first, then writes the new word, and a pop front reads the first entry, then moves
// each later entry down by one place. Every move is a read then a write, as the
// single entry memory has one registered read port and one write port.
// The result register lets the next request be accepted while a result still waits
// for its transfer; the block stalls before loading a further result until it is taken.
`default_nettype none

module indexed_list_buffer #(
   parameter int CAPACITY   = ilb_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = ilb_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ilb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ilb_pkg::rsp_type rsp_payload
);
   import ilb_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   mem_ctl_type           mem_ctl;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;

   ilb_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mem_ctl     (mem_ctl),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_data     (rd_data)
   );

   ilb_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

@@ hdl/ilb_check.sv @@
// Port checker of the indexed list buffer and the bind that attaches it to the top level.
// Depends on ilb_pkg and the assertion macros in indexed_list_buffer_defines.svh.
`default_nettype none
`include "indexed_list_buffer_defines.svh"

module ilb_check #(
   parameter int CAPACITY = ilb_pkg::CAPACITY_DEFAULT
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ilb_pkg::rsp_type rsp_payload
);
   import ilb_pkg::*;

   logic req_fire;
   logic rsp_fail;

   assign req_fire = req_valid && req_ready;
   assign rsp_fail = rsp_valid && (rsp_payload.status != STATUS_OK);

   // A stalled result must hold until its transfer completes.
   `ILB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // Only one request is in progress at a time.
   `ILB_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire,
      !req_ready, "request accepted while another was in progress")

   // A failed request never returns data.
   `ILB_ASSERT_NOW(a_fail_no_data, clock, reset, rsp_fail,
      rsp_payload.data == '0, "failed request returned data")

   // A full refusal reports a full list and an empty refusal an empty one.
   `ILB_ASSERT_NOW(a_full_count, clock, reset,
      rsp_valid && (rsp_payload.status == STATUS_FULL),
      rsp_payload.entry_count == COUNT_W'(CAPACITY), "full status with wrong count")

   `ILB_ASSERT_NOW(a_empty_count, clock, reset,
      rsp_valid && (rsp_payload.status == STATUS_EMPTY),
      rsp_payload.entry_count == '0, "empty status with nonzero count")

endmodule

bind indexed_list_buffer ilb_check #(
   .CAPACITY (CAPACITY)
) u_ilb_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench of indexed_list_buffer: directed table, then biased random requests.
// Each result is compared against the table's expected result or a list predictor kept in step with accepted requests.
// Depends on ilb_pkg and the indexed_list_buffer RTL.
`default_nettype none

module tb;
   import ilb_pkg::*;

   localparam int LIST_DEPTH = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT = 3000;
   localparam int TAIL_CYCLES = 60;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
      int                 reps;
      bit                 typed;
      rsp_type            want;
   } step_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   logic [DATA_W-1:0] list_words [LIST_DEPTH];
   int                list_len = 0;
   rsp_type           awaited_results [$];
   int                fault_count = 0;
   int                idle_cycles = 0;
   bit                req_quiet = 1'b0;
   bit                rsp_quiet = 1'b0;
   step_row_type      plan [25];

   indexed_list_buffer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_pause(bit quiet);
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic rsp_type predict_list_op(req_type r);
      rsp_type res;
      int      at;
      int      i;
      res = '0;
      res.status = STATUS_OK;
      case (r.kind)
         KIND_READ: begin
            if (r.position < list_len) res.data = list_words[r.position];
            else res.status = STATUS_RANGE;
         end
         KIND_INSERT, KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
            if (r.kind == KIND_INSERT) at = r.position;
            else if (r.kind == KIND_PUSH_BACK) at = list_len;
            else at = 0;
            if (at > list_len) begin
               res.status = STATUS_RANGE;
            end else if (list_len >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
               list_words[at] = r.value;
               list_len++;
            end
         end
         KIND_POP_BACK: begin
            if (list_len == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               list_len--;
               res.data = list_words[list_len];
            end
         end
         KIND_POP_FRONT: begin
            if (list_len == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.data = list_words[0];
               for (i = 1; i < list_len; i++) list_words[i - 1] = list_words[i];
               list_len--;
            end
         end
         KIND_CLEAR: list_len = 0;
         default: ;
      endcase
      res.entry_count = COUNT_W'(list_len);
      return res;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed requests: growing phases fill the list, shrinking phases drain it.
   function automatic req_type draw_request(bit grow);
      req_type r;
      int      pick;
      r.kind = KIND_READ;
      r.position = '0;
      r.value = pick_word();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r.kind = KIND_W'($urandom_range(0, 7));
         r.position = POS_W'($urandom_range(0, 31));
      end else if (pick < 28) begin
         r.kind = KIND_READ;
         r.position = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
      end else if (pick < 29) begin
         r.kind = KIND_CLEAR;
      end else if ((pick < 82) == grow) begin
         case ($urandom_range(0, 2))
            0: r.kind = KIND_PUSH_BACK;
            1: r.kind = KIND_PUSH_FRONT;
            default: begin
               r.kind = KIND_INSERT;
               r.position = POS_W'($urandom_range(0, list_len));
            end
         endcase
      end else begin
         r.kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
      end
      return r;
   endfunction

   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      int      pause;
      if ($urandom_range(0, 63) == 0) req_quiet = ~req_quiet;
      pause = pick_pause(req_quiet);
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predicted = predict_list_op(r);
      awaited_results = {awaited_results, (typed ? want : predicted)};
   endtask

   // Result side: a random hold-off before each transfer, with quiet stretches.
   initial begin
      int pause;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) rsp_quiet = ~rsp_quiet;
         pause = pick_pause(rsp_quiet);
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result transfer: %p", rsp_payload);
            fault_count++;
         end else begin
            want = awaited_results[0];
            awaited_results.delete(0);
            if (rsp_payload.data !== want.data) begin
               $error("data: expected %h, got %h", want.data, rsp_payload.data);
               fault_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               fault_count++;
            end
            if (rsp_payload.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_payload.entry_count);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      req_type r;
      bit      grow;
      int      row;
      int      k;
      plan = '{
         '{KIND_READ,       5'd0,  32'h0,        1,  1'b1, '{32'h0, STATUS_RANGE, 5'd0}},
         '{KIND_POP_BACK,   5'd0,  32'h0,        1,  1'b1, '{32'h0, STATUS_EMPTY, 5'd0}},
         '{KIND_POP_FRONT,  5'd0,  32'h0,        1,  1'b1, '{32'h0, STATUS_EMPTY, 5'd0}},
         '{KIND_INSERT,     5'd1,  32'h1234,     1,  1'b1, '{32'h0, STATUS_RANGE, 5'd0}},
         '{KIND_READ,       5'd31, 32'h0,        1,  1'b1, '{32'h0, STATUS_RANGE, 5'd0}},
         '{KIND_UNUSED,     5'd31, 32'hFFFFFFFF, 1,  1'b1, '{32'h0, STATUS_OK, 5'd0}},
         '{KIND_PUSH_BACK,  5'd0,  32'hFFFFFFFF, 1,  1'b0, '0},
         '{KIND_PUSH_FRONT, 5'd31, 32'h0,        1,  1'b0, '0},
         '{KIND_INSERT,     5'd1,  32'hA5A5A5A5, 1,  1'b0, '0},
         '{KIND_INSERT,     5'd3,  32'h5A5A5A5A, 1,  1'b0, '0},
         '{KIND_READ,       5'd3,  32'h0,        1,  1'b0, '0},
         '{KIND_PUSH_BACK,  5'd0,  32'h80000001, 12, 1'b0, '0},
         '{KIND_PUSH_BACK,  5'd0,  32'h1,        1,  1'b1, '{32'h0, STATUS_FULL, 5'd16}},
         '{KIND_PUSH_FRONT, 5'd0,  32'h2,        1,  1'b1, '{32'h0, STATUS_FULL, 5'd16}},
         '{KIND_INSERT,     5'd17, 32'h3,        1,  1'b1, '{32'h0, STATUS_RANGE, 5'd16}},
         '{KIND_INSERT,     5'd16, 32'h4,        1,  1'b1, '{32'h0, STATUS_FULL, 5'd16}},
         '{KIND_INSERT,     5'd0,  32'h5,        1,  1'b1, '{32'h0, STATUS_FULL, 5'd16}},
         '{KIND_READ,       5'd15, 32'h0,        1,  1'b0, '0},
         '{KIND_READ,       5'd16, 32'h0,        1,  1'b1, '{32'h0, STATUS_RANGE, 5'd16}},
         '{KIND_POP_FRONT,  5'd0,  32'h0,        1,  1'b0, '0},
         '{KIND_POP_BACK,   5'd0,  32'h0,        1,  1'b0, '0},
         '{KIND_CLEAR,      5'd9,  32'hFFFFFFFF, 1,  1'b1, '{32'h0, STATUS_OK, 5'd0}},
         '{KIND_READ,       5'd0,  32'h0,        1,  1'b1, '{32'h0, STATUS_RANGE, 5'd0}},
         '{KIND_PUSH_FRONT, 5'd0,  32'h1,        1,  1'b0, '0},
         '{KIND_POP_BACK,   5'd0,  32'h0,        1,  1'b0, '0}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < $size(plan); row++) begin
         r.kind = plan[row].kind;
         r.position = plan[row].position;
         r.value = plan[row].value;
         for (k = 0; k < plan[row].reps; k++) send_request(r, plan[row].typed, plan[row].want);
      end

      grow = 1'b1;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (grow && list_len == LIST_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
         if (!grow && list_len == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
         send_request(draw_request(grow), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/ilb_pkg.sv
hdl/ilb_store.sv
hdl/ilb_seq.sv
hdl/indexed_list_buffer.sv
hdl/ilb_check.sv
tb/sv/tb.sv
